// ----- rtl/core/lru_virtual_handle_manager_assert.svh -----
// ----------------------------------------------------------------------------
// LRU virtual handle manager: assertion macros
// Clocked, reset-qualified assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_VIRTUAL_HANDLE_MANAGER_ASSERT_SVH
`define LRU_VIRTUAL_HANDLE_MANAGER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define LVHM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that the consequent holds whenever the antecedent does.
`define LVHM_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/lvhm_pkg.sv -----
// ----------------------------------------------------------------------------
// lvhm_pkg
// Types, sizes and codes of the LRU virtual handle manager.
// ----------------------------------------------------------------------------
`default_nettype none

package lvhm_pkg;

	localparam int SLOT_COUNT = 16;
	localparam int STAMP_BITS = 32;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int HANDLE_W   = 5;
	localparam int LIMIT_W    = 5;
	localparam int CNT_W      = 5;
	localparam int STATUS_W   = 4;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(8);

	// operation codes
	localparam logic [1:0] OP_OPEN   = 2'd0;
	localparam logic [1:0] OP_ACCESS = 2'd1;
	localparam logic [1:0] OP_CLOSE  = 2'd2;
	localparam logic [1:0] OP_QUERY  = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_EVICT       = 4'd0;
	localparam logic [STATUS_W-1:0] ST_ALREADY     = 4'd1;
	localparam logic [STATUS_W-1:0] ST_REOPENED    = 4'd2;
	localparam logic [STATUS_W-1:0] ST_OPENED_NEW  = 4'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_HANDLE  = 4'd4;
	localparam logic [STATUS_W-1:0] ST_NO_FREE     = 4'd5;
	localparam logic [STATUS_W-1:0] ST_OPEN_FAILED = 4'd6;
	localparam logic [STATUS_W-1:0] ST_CLOSED_OPEN = 4'd7;
	localparam logic [STATUS_W-1:0] ST_CLOSED_EVIC = 4'd8;
	localparam logic [STATUS_W-1:0] ST_ERROR_REP   = 4'd9;

	typedef struct packed {
		logic [1:0]          op;
		logic [HANDLE_W-1:0] handle;
		logic                open_ok;
		logic                io_error;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] result_handle;
		logic                error_flag;
		logic [CNT_W-1:0]    open_now;
		logic                last;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TOUCH,
		S_CHECK,
		S_SCAN,
		S_EVICT,
		S_FINISH,
		S_OUT
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/core/lru_virtual_handle_manager.sv -----
// ----------------------------------------------------------------------------
// lru_virtual_handle_manager
// Handle table with a limit on physically open handles and LRU eviction.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request beat per item (op, handle, open_ok, io_error).
//   out_* : one or more result beats per item; the final one has last set.
//   cfg_* : write of open_limit, always ready; write it only while idle.
// One item at a time: in_ready is high only while the block is idle, and it
// returns in the cycle after the final result beat is taken.
// Path of an item through the sequencer, up to its first result beat:
//   query, close, bad handle, table full : straight to the result beat
//   access of an open slot                : touch, then the result beat
//   open/access without eviction          : touch, check, finish, result beat
//   open/access that evicts               : touch, check, scan, evict, victim beat
// Each eviction reads the 16 stamps one per cycle through a single comparator,
// behind the read register, then selects the victim and shows its beat; after
// each victim beat the sequencer checks the limit again before it finishes.
// A stalled receiver (out_ready low) holds the result beat and the whole
// sequencer; nothing is lost. Reset clears the slot flags, the use clock and
// the open count and loads open_limit with 8; stamps stay undefined until
// an open or access writes them.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_virtual_handle_manager (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire lvhm_pkg::in_item_t    in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output lvhm_pkg::out_item_t        out_data,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [lvhm_pkg::LIMIT_W-1:0] cfg_data
);

	localparam int SLOT_COUNT = lvhm_pkg::SLOT_COUNT;
	localparam int SLOT_W     = lvhm_pkg::SLOT_W;
	localparam int STAMP_BITS = lvhm_pkg::STAMP_BITS;
	localparam int HANDLE_W   = lvhm_pkg::HANDLE_W;
	localparam int CNT_W      = lvhm_pkg::CNT_W;
	localparam int STATUS_W   = lvhm_pkg::STATUS_W;

	// Turn a slot index into its virtual handle number.
	function automatic logic [HANDLE_W-1:0] slot_handle(input logic [SLOT_W-1:0] s);
		return HANDLE_W'({1'b0, s}) + HANDLE_W'(1);
	endfunction

	lvhm_pkg::state_t state_q, state_d;

	// slot flags and counters
	logic [SLOT_COUNT-1:0]   slot_used_q, slot_open_q, slot_failed_q;
	logic [STAMP_BITS-1:0]   use_clock_q;
	logic [CNT_W-1:0]        open_total_q;
	logic [lvhm_pkg::LIMIT_W-1:0] open_limit_q;

	// item being served
	lvhm_pkg::in_item_t      item_q;
	logic [SLOT_W-1:0]       slot_q;
	logic                    fresh_q;

	// stamp memory and scan datapath
	logic [STAMP_BITS-1:0]   stamp_mem [SLOT_COUNT];
	logic [SLOT_W:0]         scan_q;
	logic [SLOT_W-1:0]       scan_idx;
	logic                    scan_cand;
	logic                    valid_s1;
	logic [SLOT_W-1:0]       idx_s1;
	logic [STAMP_BITS-1:0]   rd_s1;
	logic                    best_vld_q;
	logic [SLOT_W-1:0]       best_idx_q;
	logic [STAMP_BITS-1:0]   best_q;
	logic                    take_best;

	// result register
	logic [STATUS_W-1:0]     res_status_q;
	logic [HANDLE_W-1:0]     res_handle_q;
	logic                    res_ef_q;
	logic                    res_last_q;

	// request decode
	logic                    in_fire;
	logic                    free_found;
	logic [SLOT_W-1:0]       free_idx;
	logic [HANDLE_W-1:0]     hdl_m1;
	logic                    hdl_in_range;
	logic [SLOT_W-1:0]       hsel;
	logic                    hdl_ok;
	logic                    query_ef;
	logic                    limit_hit;

	assign in_fire = in_valid && in_ready;

	// Find the lowest unused slot for an open.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!slot_used_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	// A handle names a slot only when it lies in 1..SLOT_COUNT and that slot is in use.
	assign hdl_m1       = in_data.handle - HANDLE_W'(1);
	assign hdl_in_range = (in_data.handle != '0)
		&& ({1'b0, in_data.handle} <= (HANDLE_W + 1)'(SLOT_COUNT));
	assign hsel         = hdl_m1[SLOT_W-1:0];
	assign hdl_ok       = hdl_in_range && slot_used_q[hsel];

	// Query answer: a bad handle or a sticky failure reports an error, else the stream error while open.
	always_comb begin
		if (!hdl_ok)
			query_ef = 1'b1;
		else if (slot_failed_q[hsel])
			query_ef = 1'b1;
		else
			query_ef = slot_open_q[hsel] && in_data.io_error;
	end

	assign limit_hit = ({1'b0, open_total_q} >= {1'b0, open_limit_q});

	// Scan candidate: open slot other than the one being served.
	assign scan_idx  = scan_q[SLOT_W-1:0];
	assign scan_cand = slot_used_q[scan_idx] && slot_open_q[scan_idx] && (scan_idx != slot_q);

	// Single comparator: keeps the smallest stamp, earliest slot on ties.
	assign take_best = valid_s1 && (!best_vld_q || (rd_s1 < best_q));

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lvhm_pkg::S_IDLE: begin
				if (in_fire) begin
					unique case (in_data.op)
						lvhm_pkg::OP_OPEN:
							state_d = free_found ? lvhm_pkg::S_TOUCH : lvhm_pkg::S_OUT;
						lvhm_pkg::OP_ACCESS:
							state_d = hdl_ok ? lvhm_pkg::S_TOUCH : lvhm_pkg::S_OUT;
						default:
							state_d = lvhm_pkg::S_OUT;
					endcase
				end
			end
			lvhm_pkg::S_TOUCH:
				state_d = slot_open_q[slot_q] ? lvhm_pkg::S_OUT : lvhm_pkg::S_CHECK;
			lvhm_pkg::S_CHECK:
				state_d = limit_hit ? lvhm_pkg::S_SCAN : lvhm_pkg::S_FINISH;
			lvhm_pkg::S_SCAN: begin
				if (scan_q == (SLOT_W + 1)'(SLOT_COUNT))
					state_d = lvhm_pkg::S_EVICT;
			end
			lvhm_pkg::S_EVICT:
				state_d = best_vld_q ? lvhm_pkg::S_OUT : lvhm_pkg::S_FINISH;
			lvhm_pkg::S_FINISH:
				state_d = lvhm_pkg::S_OUT;
			lvhm_pkg::S_OUT: begin
				if (out_ready)
					state_d = res_last_q ? lvhm_pkg::S_IDLE : lvhm_pkg::S_CHECK;
			end
			default:
				state_d = lvhm_pkg::S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Handshake outputs
	// ------------------------------------------------------------------
	always_comb begin
		in_ready  = (state_q == lvhm_pkg::S_IDLE);
		out_valid = (state_q == lvhm_pkg::S_OUT);
		cfg_ready = 1'b1;
	end

	// open_now follows the count, which is settled before the beat is shown
	assign out_data = '{
		status:        res_status_q,
		result_handle: res_handle_q,
		error_flag:    res_ef_q,
		open_now:      open_total_q,
		last:          res_last_q
	};

	// ------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= lvhm_pkg::S_IDLE;
			slot_used_q   <= '0;
			slot_open_q   <= '0;
			slot_failed_q <= '0;
			use_clock_q   <= '0;
			open_total_q  <= '0;
			open_limit_q  <= lvhm_pkg::LIMIT_RESET;
			scan_q        <= '0;
			best_vld_q    <= 1'b0;
			valid_s1      <= 1'b0;
		end else begin
			state_q  <= state_d;
			// issue stage of the scan: flag whether the read slot competes
			valid_s1 <= (state_q == lvhm_pkg::S_SCAN)
				&& (scan_q != (SLOT_W + 1)'(SLOT_COUNT)) && scan_cand;

			if (cfg_valid && cfg_ready)
				open_limit_q <= cfg_data;

			case (state_q)
				lvhm_pkg::S_IDLE: begin
					if (in_fire) begin
						if (in_data.op == lvhm_pkg::OP_OPEN && free_found) begin
							// claim the slot fresh
							slot_used_q[free_idx]   <= 1'b1;
							slot_open_q[free_idx]   <= 1'b0;
							slot_failed_q[free_idx] <= 1'b0;
						end else if (in_data.op == lvhm_pkg::OP_CLOSE && hdl_ok) begin
							if (slot_open_q[hsel])
								open_total_q <= open_total_q - CNT_W'(1);
							slot_open_q[hsel] <= 1'b0;
							slot_used_q[hsel] <= 1'b0;
						end
					end
				end
				lvhm_pkg::S_TOUCH:
					use_clock_q <= use_clock_q + STAMP_BITS'(1);
				lvhm_pkg::S_CHECK: begin
					scan_q     <= '0;
					best_vld_q <= 1'b0;
				end
				lvhm_pkg::S_SCAN: begin
					scan_q <= scan_q + (SLOT_W + 1)'(1);
					if (take_best)
						best_vld_q <= 1'b1;
				end
				lvhm_pkg::S_EVICT: begin
					if (best_vld_q) begin
						slot_open_q[best_idx_q] <= 1'b0;
						open_total_q            <= open_total_q - CNT_W'(1);
					end
				end
				lvhm_pkg::S_FINISH: begin
					if (item_q.open_ok) begin
						slot_open_q[slot_q] <= 1'b1;
						open_total_q        <= open_total_q + CNT_W'(1);
					end else begin
						slot_failed_q[slot_q] <= 1'b1;
						if (fresh_q)
							slot_used_q[slot_q] <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stamp memory: one write port (touch), one registered read port (scan)
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (state_q == lvhm_pkg::S_TOUCH)
			stamp_mem[slot_q] <= use_clock_q + STAMP_BITS'(1);
		rd_s1  <= stamp_mem[scan_idx];
		idx_s1 <= scan_idx;
	end

	// ------------------------------------------------------------------
	// Payload: item, best candidate and the result beat
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			lvhm_pkg::S_IDLE: begin
				if (in_fire) begin
					item_q  <= in_data;
					fresh_q <= (in_data.op == lvhm_pkg::OP_OPEN);
					slot_q  <= (in_data.op == lvhm_pkg::OP_OPEN) ? free_idx : hsel;
					res_last_q <= 1'b1;
					unique case (in_data.op)
						lvhm_pkg::OP_OPEN: begin
							res_status_q <= lvhm_pkg::ST_NO_FREE;
							res_handle_q <= '0;
							res_ef_q     <= 1'b0;
						end
						lvhm_pkg::OP_ACCESS: begin
							res_status_q <= lvhm_pkg::ST_BAD_HANDLE;
							res_handle_q <= in_data.handle;
							res_ef_q     <= 1'b0;
						end
						lvhm_pkg::OP_CLOSE: begin
							res_handle_q <= in_data.handle;
							res_ef_q     <= 1'b0;
							if (!hdl_ok)
								res_status_q <= lvhm_pkg::ST_BAD_HANDLE;
							else if (slot_open_q[hsel])
								res_status_q <= lvhm_pkg::ST_CLOSED_OPEN;
							else
								res_status_q <= lvhm_pkg::ST_CLOSED_EVIC;
						end
						default: begin
							res_status_q <= lvhm_pkg::ST_ERROR_REP;
							res_handle_q <= in_data.handle;
							res_ef_q     <= query_ef;
						end
					endcase
				end
			end
			lvhm_pkg::S_TOUCH: begin
				// already open: answer at once
				res_status_q <= lvhm_pkg::ST_ALREADY;
				res_handle_q <= slot_handle(slot_q);
				res_ef_q     <= 1'b0;
				res_last_q   <= 1'b1;
			end
			lvhm_pkg::S_SCAN: begin
				if (take_best) begin
					best_q     <= rd_s1;
					best_idx_q <= idx_s1;
				end
			end
			lvhm_pkg::S_EVICT: begin
				res_status_q <= lvhm_pkg::ST_EVICT;
				res_handle_q <= slot_handle(best_idx_q);
				res_ef_q     <= 1'b0;
				res_last_q   <= 1'b0;
			end
			lvhm_pkg::S_FINISH: begin
				res_ef_q   <= 1'b0;
				res_last_q <= 1'b1;
				if (item_q.open_ok) begin
					res_status_q <= fresh_q ? lvhm_pkg::ST_OPENED_NEW : lvhm_pkg::ST_REOPENED;
					res_handle_q <= slot_handle(slot_q);
				end else begin
					res_status_q <= lvhm_pkg::ST_OPEN_FAILED;
					res_handle_q <= fresh_q ? '0 : slot_handle(slot_q);
				end
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
`include "lru_virtual_handle_manager_assert.svh"

	`LVHM_ASSERT_ALWAYS(a_open_count, open_total_q == CNT_W'($countones(slot_open_q)), "open count out of step with slot flags")
	`LVHM_ASSERT_ALWAYS(a_open_used, (slot_open_q & ~slot_used_q) == '0, "open slot not in use")
	`LVHM_ASSERT_ALWAYS(a_one_side, !(in_ready && out_valid), "request taken while a result is pending")
	`LVHM_ASSERT_IMPLY(a_victim_other, out_valid && (res_status_q == lvhm_pkg::ST_EVICT), (res_handle_q != slot_handle(slot_q)) && !res_last_q, "served slot chosen as victim")

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Handle manager testbench
// Drives open, access, close and query requests into the LRU handle manager
// and checks every result beat against an in-bench model of the handle table.
// A short directed table comes first, then random traffic under several open
// limits and back-pressure patterns.
// ----------------------------------------------------------------------------

module testbench;

	localparam int ITEMS_PER_PHASE = 58;
	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int TAIL_CYCLES     = 40;
	localparam int REPORT_MAX      = 10;

	// One row of the directed table: either a limit write or a request beat,
	// optionally with a hand-written expected result.
	typedef struct {
		bit                           is_cfg;
		logic [lvhm_pkg::LIMIT_W-1:0] limit;
		lvhm_pkg::in_item_t           req;
		bit                           typed;
		lvhm_pkg::out_item_t          want;
	} plan_row_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	lvhm_pkg::in_item_t            in_data = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	lvhm_pkg::out_item_t           out_data;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [lvhm_pkg::LIMIT_W-1:0]  cfg_data = '0;

	// Idle percentages for the sender and the receiver in the current phase.
	int tx_pct = 0;
	int rx_pct = 0;

	int fail_count = 0;
	int quiet_cycles = 0;

	// Model of the handle table.
	logic [lvhm_pkg::LIMIT_W-1:0]    open_limit_q = lvhm_pkg::LIMIT_RESET;
	bit                              slot_in_use [lvhm_pkg::SLOT_COUNT];
	bit                              slot_is_open [lvhm_pkg::SLOT_COUNT];
	bit                              slot_has_failed [lvhm_pkg::SLOT_COUNT];
	bit [lvhm_pkg::STAMP_BITS-1:0]   slot_stamp [lvhm_pkg::SLOT_COUNT];
	bit [lvhm_pkg::STAMP_BITS-1:0]   use_count = '0;
	logic [lvhm_pkg::CNT_W-1:0]      open_count = '0;

	// Result beats still owed by the block, oldest first.
	lvhm_pkg::out_item_t expected_beats [$];

	lru_virtual_handle_manager u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Handle table model
	// ------------------------------------------------------------------------

	function automatic void queue_beat(logic [lvhm_pkg::STATUS_W-1:0] st,
			logic [lvhm_pkg::HANDLE_W-1:0] h, logic ef, logic lst);
		lvhm_pkg::out_item_t b;
		b.status        = st;
		b.result_handle = h;
		b.error_flag    = ef;
		b.open_now      = open_count;
		b.last          = lst;
		expected_beats.push_back(b);
	endfunction

	// Pick the open slot with the smallest stamp, skipping keep; lowest slot wins a tie.
	function automatic int oldest_open(int keep);
		int v = -1;
		for (int i = 0; i < lvhm_pkg::SLOT_COUNT; i++) begin
			if (slot_in_use[i] && slot_is_open[i] && i != keep) begin
				if (v < 0 || slot_stamp[i] < slot_stamp[v])
					v = i;
			end
		end
		return v;
	endfunction

	// Stamp slot s, evict down to the limit if it must open, then try the open.
	function automatic void touch_slot(int s, bit fresh, logic ok);
		int v;
		use_count = use_count + lvhm_pkg::STAMP_BITS'(1);
		slot_stamp[s] = use_count;
		if (slot_is_open[s]) begin
			queue_beat(lvhm_pkg::ST_ALREADY, lvhm_pkg::HANDLE_W'(s + 1), 1'b0, 1'b1);
			return;
		end
		while (open_count >= open_limit_q) begin
			v = oldest_open(s);
			if (v < 0)
				break;
			slot_is_open[v] = 1'b0;
			open_count = open_count - lvhm_pkg::CNT_W'(1);
			queue_beat(lvhm_pkg::ST_EVICT, lvhm_pkg::HANDLE_W'(v + 1), 1'b0, 1'b0);
		end
		if (ok) begin
			slot_is_open[s] = 1'b1;
			open_count = open_count + lvhm_pkg::CNT_W'(1);
			queue_beat(fresh ? lvhm_pkg::ST_OPENED_NEW : lvhm_pkg::ST_REOPENED,
				lvhm_pkg::HANDLE_W'(s + 1), 1'b0, 1'b1);
		end else begin
			slot_has_failed[s] = 1'b1;
			if (fresh) begin
				// no handle was issued, so give the slot back
				slot_in_use[s] = 1'b0;
				queue_beat(lvhm_pkg::ST_OPEN_FAILED, '0, 1'b0, 1'b1);
			end else begin
				queue_beat(lvhm_pkg::ST_OPEN_FAILED, lvhm_pkg::HANDLE_W'(s + 1), 1'b0, 1'b1);
			end
		end
	endfunction

	function automatic void predict_request(lvhm_pkg::in_item_t d);
		int s = -1;
		logic ef;
		if (d.op == lvhm_pkg::OP_OPEN) begin
			for (int i = 0; i < lvhm_pkg::SLOT_COUNT; i++) begin
				if (!slot_in_use[i]) begin
					s = i;
					break;
				end
			end
			if (s < 0) begin
				queue_beat(lvhm_pkg::ST_NO_FREE, '0, 1'b0, 1'b1);
				return;
			end
			slot_in_use[s]     = 1'b1;
			slot_is_open[s]    = 1'b0;
			slot_has_failed[s] = 1'b0;
			touch_slot(s, 1'b1, d.open_ok);
			return;
		end
		if (d.handle >= 1 && d.handle <= lvhm_pkg::SLOT_COUNT
				&& slot_in_use[int'(d.handle) - 1])
			s = int'(d.handle) - 1;
		if (d.op == lvhm_pkg::OP_QUERY) begin
			ef = 1'b1;
			if (s >= 0)
				ef = slot_has_failed[s] ? 1'b1 : (slot_is_open[s] ? d.io_error : 1'b0);
			queue_beat(lvhm_pkg::ST_ERROR_REP, d.handle, ef, 1'b1);
			return;
		end
		if (s < 0) begin
			queue_beat(lvhm_pkg::ST_BAD_HANDLE, d.handle, 1'b0, 1'b1);
			return;
		end
		if (d.op == lvhm_pkg::OP_ACCESS) begin
			touch_slot(s, 1'b0, d.open_ok);
			return;
		end
		slot_in_use[s] = 1'b0;
		if (slot_is_open[s]) begin
			slot_is_open[s] = 1'b0;
			open_count = open_count - lvhm_pkg::CNT_W'(1);
			queue_beat(lvhm_pkg::ST_CLOSED_OPEN, d.handle, 1'b0, 1'b1);
		end else begin
			queue_beat(lvhm_pkg::ST_CLOSED_EVIC, d.handle, 1'b0, 1'b1);
		end
	endfunction

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// Present one request beat after a random idle gap and hold it until taken.
	// valid is left high afterwards so back-to-back beats need no extra edge.
	task automatic admit_request(lvhm_pkg::in_item_t d, bit typed,
			lvhm_pkg::out_item_t want);
		int queued;
		@(negedge clk);
		while ($urandom_range(99) < tx_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= d;
		forever begin
			@(posedge clk);
			if (in_ready)
				break;
		end
		queued = expected_beats.size();
		predict_request(d);
		// a hand-written row replaces the model's answer, the model still tracks state
		if (typed) begin
			while (expected_beats.size() > queued)
				void'(expected_beats.pop_back());
			expected_beats.push_back(want);
		end
	endtask

	// Drop valid and hold off until every owed beat has come and the block is idle.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		forever begin
			@(posedge clk);
			if (in_ready)
				break;
		end
	endtask

	task automatic write_open_limit(logic [lvhm_pkg::LIMIT_W-1:0] v);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		open_limit_q = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic plan_row_t req_row(logic [1:0] op, logic [lvhm_pkg::HANDLE_W-1:0] h,
			logic ok, logic ioe);
		plan_row_t r;
		r.is_cfg = 1'b0;
		r.limit  = '0;
		r.req    = '{op: op, handle: h, open_ok: ok, io_error: ioe};
		r.typed  = 1'b0;
		r.want   = '0;
		return r;
	endfunction

	function automatic plan_row_t with_result(plan_row_t r,
			logic [lvhm_pkg::STATUS_W-1:0] st, logic [lvhm_pkg::HANDLE_W-1:0] h,
			logic ef, logic [lvhm_pkg::CNT_W-1:0] cnt);
		r.typed = 1'b1;
		r.want  = '{status: st, result_handle: h, error_flag: ef, open_now: cnt, last: 1'b1};
		return r;
	endfunction

	function automatic plan_row_t limit_row(logic [lvhm_pkg::LIMIT_W-1:0] v);
		plan_row_t r;
		r = req_row(lvhm_pkg::OP_QUERY, '0, 1'b0, 1'b0);
		r.is_cfg = 1'b1;
		r.limit  = v;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Receiver and checker
	// ------------------------------------------------------------------------

	// Stall the result channel at the phase's rate; rx_pct of zero never stalls.
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= rx_pct);

	function automatic void report_beat(string what, lvhm_pkg::out_item_t want,
			lvhm_pkg::out_item_t got);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("ERROR %0t: %s: expected st=%0d h=%0d ef=%0b open=%0d last=%0b, ",
				$time, what, want.status, want.result_handle, want.error_flag,
				want.open_now, want.last,
				"got st=%0d h=%0d ef=%0b open=%0d last=%0b",
				got.status, got.result_handle, got.error_flag,
				got.open_now, got.last);
	endfunction

	always @(posedge clk) begin
		lvhm_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_beats.size() == 0) begin
				report_beat("result beat with nothing owed", '0, out_data);
			end else begin
				want = expected_beats.pop_front();
				if (out_data.status !== want.status
						|| out_data.result_handle !== want.result_handle
						|| out_data.error_flag !== want.error_flag
						|| out_data.open_now !== want.open_now
						|| out_data.last !== want.last)
					report_beat("result beat differs", want, out_data);
			end
		end
	end

	// End the run if no beat moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	initial begin
		plan_row_t plan [$];
		logic [lvhm_pkg::LIMIT_W-1:0] phase_limits [8] = '{5'd16, 5'd1, 5'd3, 5'd0,
			5'd8, 5'd31, 5'd2, 5'd5};
		lvhm_pkg::in_item_t d;
		int roll;
		int nused;
		int cand [lvhm_pkg::SLOT_COUNT];
		int open_w;
		int close_w;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Out of reset with the default limit: bad handles, failed new open,
		// first open, touch of an open slot and its error query.
		plan.push_back(with_result(req_row(lvhm_pkg::OP_QUERY, 5'd0, 1'b0, 1'b1),
			lvhm_pkg::ST_ERROR_REP, 5'd0, 1'b1, 5'd0));
		plan.push_back(with_result(req_row(lvhm_pkg::OP_ACCESS, 5'd16, 1'b1, 1'b0),
			lvhm_pkg::ST_BAD_HANDLE, 5'd16, 1'b0, 5'd0));
		plan.push_back(with_result(req_row(lvhm_pkg::OP_CLOSE, 5'd0, 1'b1, 1'b1),
			lvhm_pkg::ST_BAD_HANDLE, 5'd0, 1'b0, 5'd0));
		plan.push_back(with_result(req_row(lvhm_pkg::OP_OPEN, 5'd31, 1'b0, 1'b0),
			lvhm_pkg::ST_OPEN_FAILED, 5'd0, 1'b0, 5'd0));
		plan.push_back(with_result(req_row(lvhm_pkg::OP_OPEN, 5'd0, 1'b1, 1'b0),
			lvhm_pkg::ST_OPENED_NEW, 5'd1, 1'b0, 5'd1));
		plan.push_back(with_result(req_row(lvhm_pkg::OP_ACCESS, 5'd1, 1'b0, 1'b0),
			lvhm_pkg::ST_ALREADY, 5'd1, 1'b0, 5'd1));
		plan.push_back(with_result(req_row(lvhm_pkg::OP_QUERY, 5'd1, 1'b0, 1'b1),
			lvhm_pkg::ST_ERROR_REP, 5'd1, 1'b1, 5'd1));
		plan.push_back(req_row(lvhm_pkg::OP_QUERY, 5'd1, 1'b1, 1'b0));
		// Limit of one: each open evicts, a failed reopen leaves a sticky error.
		plan.push_back(limit_row(5'd1));
		plan.push_back(req_row(lvhm_pkg::OP_OPEN, 5'd16, 1'b1, 1'b0));
		plan.push_back(req_row(lvhm_pkg::OP_ACCESS, 5'd1, 1'b0, 1'b1));
		plan.push_back(req_row(lvhm_pkg::OP_QUERY, 5'd1, 1'b1, 1'b0));
		plan.push_back(req_row(lvhm_pkg::OP_CLOSE, 5'd1, 1'b0, 1'b0));
		// Limit of zero behaves like one; close of an open slot, query of a freed one.
		plan.push_back(limit_row(5'd0));
		plan.push_back(req_row(lvhm_pkg::OP_OPEN, 5'd0, 1'b1, 1'b1));
		plan.push_back(req_row(lvhm_pkg::OP_ACCESS, 5'd2, 1'b1, 1'b0));
		plan.push_back(req_row(lvhm_pkg::OP_CLOSE, 5'd2, 1'b1, 1'b0));
		plan.push_back(req_row(lvhm_pkg::OP_QUERY, 5'd2, 1'b0, 1'b0));
		plan.push_back(req_row(lvhm_pkg::OP_ACCESS, 5'd5, 1'b1, 1'b0));
		// Limit far above the table: opens never evict.
		plan.push_back(limit_row(5'd31));
		plan.push_back(req_row(lvhm_pkg::OP_OPEN, 5'd0, 1'b1, 1'b0));
		plan.push_back(req_row(lvhm_pkg::OP_OPEN, 5'd0, 1'b1, 1'b0));
		plan.push_back(req_row(lvhm_pkg::OP_ACCESS, 5'd1, 1'b1, 1'b0));

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_open_limit(plan[i].limit);
			else
				admit_request(plan[i].req, plan[i].typed, plan[i].want);
		end

		// Random traffic: one phase per limit, cycling through the idle patterns.
		// Handles mostly name slots in use so requests get past the bad-handle check.
		for (int ph = 0; ph < 8; ph++) begin
			write_open_limit(phase_limits[ph]);
			tx_pct = (ph % 4 == 1) ? 87 : (ph % 4 == 3) ? 21 : 0;
			rx_pct = (ph % 4 == 2) ? 87 : (ph % 4 == 3) ? 21 : 0;
			// with a wide limit lean on opens so the table fills up
			open_w  = (phase_limits[ph] >= lvhm_pkg::SLOT_COUNT) ? 60 : 30;
			close_w = (phase_limits[ph] >= lvhm_pkg::SLOT_COUNT) ? 5 : 20;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				roll = $urandom_range(99);
				if (roll < open_w)
					d.op = lvhm_pkg::OP_OPEN;
				else if (roll < open_w + close_w)
					d.op = lvhm_pkg::OP_CLOSE;
				else if (roll < open_w + close_w + 20)
					d.op = lvhm_pkg::OP_QUERY;
				else
					d.op = lvhm_pkg::OP_ACCESS;
				nused = 0;
				for (int i = 0; i < lvhm_pkg::SLOT_COUNT; i++) begin
					if (slot_in_use[i]) begin
						cand[nused] = i;
						nused++;
					end
				end
				// the fallback range reaches a little past the table
				if (nused != 0 && $urandom_range(99) < 85)
					d.handle = lvhm_pkg::HANDLE_W'(cand[$urandom_range(nused - 1)] + 1);
				else
					d.handle = lvhm_pkg::HANDLE_W'($urandom_range(lvhm_pkg::SLOT_COUNT + 2));
				d.open_ok  = ($urandom_range(99) < 85);
				d.io_error = 1'($urandom_range(1));
				// now and then let the block run dry before the next request
				if ($urandom_range(39) == 0)
					settle();
				admit_request(d, 1'b0, '0);
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_beats.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
